// File: hdl/velocity_source_fusion_ema_assert.svh
// Assertion macros for the velocity source fusion block.
`ifndef VELOCITY_SOURCE_FUSION_EMA_ASSERT_SVH
`define VELOCITY_SOURCE_FUSION_EMA_ASSERT_SVH

// implication checked on every clock while out of reset
`define VSF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsf assertion failed");

// condition that must never hold out of reset
`define VSF_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("vsf assertion failed");

`endif

// File: hdl/vsf_pkg.sv
// Types, constants and helper functions for the velocity source fusion block.
package vsf_pkg;

    localparam logic [1:0] FUNC_IMU  = 2'd0;
    localparam logic [1:0] FUNC_POSE = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [1:0] SRC_IMU  = 2'd0;
    localparam logic [1:0] SRC_POSE = 2'd1;
    localparam logic [1:0] SRC_NONE = 2'd2;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMU_TIMEOUT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSE_TIMEOUT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_LIMIT  = 3'd4;

    localparam logic [31:0] RST_IMU_TIMEOUT  = 32'd500000;
    localparam logic [31:0] RST_POSE_TIMEOUT = 32'd500000;
    localparam logic [16:0] RST_ALPHA        = 17'd45875;
    localparam logic [31:0] RST_MIN_INTERVAL = 32'd1000;
    localparam logic [30:0] RST_SPEED_LIMIT  = 31'd655360;

    localparam logic [16:0] ALPHA_ONE     = 17'd65536;
    localparam logic [23:0] KINV_Q24      = 24'd10188014;
    localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
    localparam int          DIV_BITS      = 53;
    localparam int          QUAT_PRODUCTS = 8;
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        now_time;
        logic [31:0]        sample_stamp;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] est_vel_x;
        logic signed [31:0] est_vel_y;
        logic [1:0]         source_used;
        logic               sensors_healthy;
        logic signed [31:0] pose_out_x;
        logic signed [31:0] pose_out_y;
    } out_res_t;

    typedef struct packed {
        logic [31:0] imu_timeout_us;
        logic [31:0] pose_timeout_us;
        logic [16:0] filter_alpha;
        logic [31:0] min_interval_us;
        logic [30:0] speed_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_IMU,
        OP_POSE,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t     op;
        in_req_t req;
    } queue_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_POSE_DIV,
        B_POSE_CHECK,
        B_POSE_SCALE_X,
        B_POSE_SCALE_Y,
        B_POSE_CORDIC,
        B_POSE_ROUND,
        B_TICK_SEL,
        B_TICK_M0,
        B_TICK_M1,
        B_TICK_M2,
        B_TICK_M3,
        B_TICK_M4,
        B_TICK_OUT
    } back_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7fffffff;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_mag(input logic [DIV_BITS-1:0] q,
                                                   input logic neg);
        logic signed [31:0] r;
        logic [DIV_BITS-1:0] lim;
        lim = DIV_BITS'(32'h80000000);
        if (!neg)
            r = (q >= lim) ? 32'sh7fffffff : $signed(q[31:0]);
        else
            r = (q >= lim) ? 32'sh80000000 : -$signed(q[31:0]);
        return r;
    endfunction

endpackage

// File: hdl/velocity_source_fusion_ema.sv
// Velocity source fusion top level: configuration registers, front end queue and back end.
// Requests go into a four-entry queue and are executed one at a time by the back end.
// An IMU request and a rejected or first pose are handled in the idle state; an accepted
// pose passes through the bit-serial rate divider, the check, the X and Y scaling states,
// the rotation unit and rounding, or stops after the check when the quaternion is
// pitch-singular, and a tick passes through source selection and the shared smoothing
// multiplier, plus any wait for the result register.
// Ticks produce one result each; other requests produce none.
module velocity_source_fusion_ema import vsf_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_req_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_res_t               out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

`include "velocity_source_fusion_ema_assert.svh"

    cfg_t   cfg_reg;
    logic   q_valid;
    logic   q_pop;
    queue_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.imu_timeout_us  <= RST_IMU_TIMEOUT;
            cfg_reg.pose_timeout_us <= RST_POSE_TIMEOUT;
            cfg_reg.filter_alpha    <= RST_ALPHA;
            cfg_reg.min_interval_us <= RST_MIN_INTERVAL;
            cfg_reg.speed_limit     <= RST_SPEED_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMU_TIMEOUT:  cfg_reg.imu_timeout_us  <= cfg_data;
                CFG_POSE_TIMEOUT: cfg_reg.pose_timeout_us <= cfg_data;
                CFG_ALPHA:        cfg_reg.filter_alpha    <= cfg_data[16:0];
                CFG_MIN_INTERVAL: cfg_reg.min_interval_us <= cfg_data;
                CFG_SPEED_LIMIT:  cfg_reg.speed_limit     <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    vsf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    vsf_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `VSF_ASSERT_IMPL(a_pop_needs_item, q_pop, q_valid)
    `VSF_ASSERT_IMPL(a_none_is_unhealthy, out_valid && out_data.source_used == SRC_NONE, !out_data.sensors_healthy)
    `VSF_ASSERT_NEVER(a_src_code, out_valid && out_data.source_used == 2'd3)

endmodule

// File: hdl/vsf_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module vsf_front import vsf_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  in_req_t in_data,
    output logic    q_valid,
    output queue_t  q_item,
    input  logic    q_pop
);

    queue_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              known;
    op_t               op;

    always_comb
    begin
        known = 1'b1;
        op    = OP_TICK;
        case (in_data.func)
            FUNC_IMU:  op = OP_IMU;
            FUNC_POSE: op = OP_POSE;
            FUNC_TICK: op = OP_TICK;
            default:   known = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready && known;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !q_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && q_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= '{op: op, req: in_data};
    end

endmodule

// File: hdl/vsf_back.sv
// Back end: sensor state, pose differentiation, yaw rotation, smoothing and result register.
module vsf_back import vsf_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     q_valid,
    input  queue_t   q_item,
    output logic     q_pop,
    output logic     out_valid,
    input  logic     out_ready,
    output out_res_t out_data
);

    localparam int CW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int DCW = $clog2(DIV_BITS);

    back_state_t state_reg, state_next;
    in_req_t     cur_reg;

    logic [31:0]        imu_arrival_reg, pose_arrival_reg, prev_stamp_reg;
    logic signed [31:0] imu_vx_reg, imu_vy_reg, prev_x_reg, prev_y_reg;
    logic signed [31:0] body_x_reg, body_y_reg, last_x_reg, last_y_reg;
    logic signed [31:0] filt_x_reg, filt_y_reg;
    logic               imu_seen_reg, pose_seen_reg;

    logic [31:0]          dt_reg;
    logic [DIV_BITS-1:0]  numx_reg, numy_reg, quox_reg, quoy_reg;
    logic [31:0]          remx_reg, remy_reg;
    logic                 negx_reg, negy_reg;
    logic [DCW-1:0]       cnt_reg;
    logic signed [33:0]   dq_reg, pq_reg, yz_reg, sq_reg;
    logic signed [31:0]   gx_reg, gy_reg;
    logic signed [35:0]   c_reg, s_reg;
    logic signed [63:0]   vx_reg, vy_reg;
    logic                 neg_reg;
    logic [CW-1:0]        step_reg;

    logic signed [31:0] tx_reg, ty_reg;
    logic [1:0]         src_reg;
    logic               healthy_reg;
    logic signed [51:0] acc_reg;

    logic     out_valid_reg;
    out_res_t out_reg;

    // pose acceptance
    logic [31:0]        dt_new;
    logic               pose_go;
    logic signed [32:0] dx, dy;
    logic [32:0]        ax, ay;

    assign dt_new  = q_item.req.sample_stamp - prev_stamp_reg;
    assign pose_go = pose_seen_reg && (dt_new != '0) && (dt_new >= cfg.min_interval_us);
    assign dx = {q_item.req.value_x[31], q_item.req.value_x} - {prev_x_reg[31], prev_x_reg};
    assign dy = {q_item.req.value_y[31], q_item.req.value_y} - {prev_y_reg[31], prev_y_reg};
    assign ax = dx[32] ? 33'(-dx) : 33'(dx);
    assign ay = dy[32] ? 33'(-dy) : 33'(dy);

    // divider step
    logic [32:0]         rsx, rsy;
    logic                bx, by;
    logic [DIV_BITS-1:0] qx_fin, qy_fin;
    assign rsx    = {remx_reg, numx_reg[DIV_BITS-1]};
    assign rsy    = {remy_reg, numy_reg[DIV_BITS-1]};
    assign bx     = (rsx >= {1'b0, dt_reg});
    assign by     = (rsy >= {1'b0, dt_reg});
    assign qx_fin = {quox_reg[DIV_BITS-2:0], bx};
    assign qy_fin = {quoy_reg[DIV_BITS-2:0], by};

    // quaternion products, one per divider cycle over the first QUAT_PRODUCTS divider steps
    logic signed [15:0] qa, qb;
    logic signed [31:0] qprod;
    logic signed [33:0] qp;
    always_comb
    begin
        qa = cur_reg.quat_x;
        qb = cur_reg.quat_x;
        case (cnt_reg[2:0])
            3'd0:    begin qa = cur_reg.quat_x; qb = cur_reg.quat_x; end
            3'd1:    begin qa = cur_reg.quat_y; qb = cur_reg.quat_y; end
            3'd2:    begin qa = cur_reg.quat_z; qb = cur_reg.quat_z; end
            3'd3:    begin qa = cur_reg.quat_w; qb = cur_reg.quat_w; end
            3'd4:    begin qa = cur_reg.quat_x; qb = cur_reg.quat_z; end
            3'd5:    begin qa = cur_reg.quat_w; qb = cur_reg.quat_y; end
            3'd6:    begin qa = cur_reg.quat_x; qb = cur_reg.quat_y; end
            default: begin qa = cur_reg.quat_w; qb = cur_reg.quat_z; end
        endcase
    end
    assign qprod = qa * qb;
    assign qp    = 34'(qprod);

    // singular check and CORDIC seed
    logic signed [35:0] c_seed, s_seed, p2, p2_abs;
    assign c_seed = 36'(dq_reg) - (36'(yz_reg) <<< 1);
    assign s_seed = 36'(sq_reg) <<< 1;
    assign p2     = 36'(pq_reg) <<< 1;
    assign p2_abs = p2[35] ? -p2 : p2;

    // velocity scaling by the CORDIC gain inverse
    logic signed [31:0] sc_in;
    logic signed [56:0] sc_prod;
    logic signed [63:0] sc_val;
    assign sc_in   = (state_reg == B_POSE_SCALE_Y) ? gy_reg : gx_reg;
    assign sc_prod = sc_in * $signed({1'b0, KINV_Q24});
    assign sc_val  = neg_reg ? -64'(sc_prod) : 64'(sc_prod);

    // CORDIC micro-rotation
    logic signed [35:0] c_sh, s_sh;
    logic signed [63:0] vx_sh, vy_sh;
    assign c_sh  = c_reg >>> step_reg;
    assign s_sh  = s_reg >>> step_reg;
    assign vx_sh = vx_reg >>> step_reg;
    assign vy_sh = vy_reg >>> step_reg;

    logic signed [63:0] rx, ry;
    assign rx = (vx_reg + 64'sd8388608) >>> 24;
    assign ry = (vy_reg + 64'sd8388608) >>> 24;

    // tick source selection
    logic               imu_live, pose_live;
    logic signed [32:0] lim;
    logic signed [31:0] clx, cly;
    assign imu_live  = imu_seen_reg
                    && ((cur_reg.now_time - imu_arrival_reg) < cfg.imu_timeout_us);
    assign pose_live = pose_seen_reg
                    && ((cur_reg.now_time - pose_arrival_reg) < cfg.pose_timeout_us);
    assign lim = {2'b00, cfg.speed_limit};

    function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
                                                  input logic signed [32:0] l);
        logic signed [32:0] w;
        logic signed [32:0] r;
        w = 33'(v);
        if (w > l)
            r = l;
        else if (w < -l)
            r = -l;
        else
            r = w;
        return r[31:0];
    endfunction

    assign clx = clampv(body_x_reg, lim);
    assign cly = clampv(body_y_reg, lim);

    // smoothing multiplier
    logic [16:0]        alpha, nalpha;
    logic signed [31:0] ma;
    logic signed [17:0] mb;
    logic signed [49:0] mprod;
    logic signed [63:0] ema_val;
    assign alpha  = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
    assign nalpha = ALPHA_ONE - alpha;

    always_comb
    begin
        ma = filt_x_reg;
        mb = $signed({1'b0, nalpha});
        case (state_reg)
            B_TICK_M0: begin ma = filt_x_reg; mb = $signed({1'b0, nalpha}); end
            B_TICK_M1: begin ma = tx_reg;     mb = $signed({1'b0, alpha});  end
            B_TICK_M2: begin ma = filt_y_reg; mb = $signed({1'b0, nalpha}); end
            B_TICK_M3: begin ma = ty_reg;     mb = $signed({1'b0, alpha});  end
            default:   begin ma = filt_x_reg; mb = $signed({1'b0, nalpha}); end
        endcase
    end
    assign mprod   = ma * mb;
    assign ema_val = 64'((acc_reg + 52'sd32768) >>> 16);

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (q_valid)
                begin
                    if (q_item.op == OP_TICK)
                        state_next = B_TICK_SEL;
                    else if (q_item.op == OP_POSE && pose_go)
                        state_next = B_POSE_DIV;
                end
            B_POSE_DIV:
                if (cnt_reg == DCW'(DIV_BITS-1))
                    state_next = B_POSE_CHECK;
            B_POSE_CHECK:
                state_next = (p2_abs >= 36'(dq_reg)) ? B_IDLE : B_POSE_SCALE_X;
            B_POSE_SCALE_X:
                state_next = B_POSE_SCALE_Y;
            B_POSE_SCALE_Y:
                state_next = B_POSE_CORDIC;
            B_POSE_CORDIC:
                if (step_reg == CW'(CORDIC_STEPS-1))
                    state_next = B_POSE_ROUND;
            B_POSE_ROUND:
                state_next = B_IDLE;
            B_TICK_SEL:
                state_next = B_TICK_M0;
            B_TICK_M0:
                state_next = B_TICK_M1;
            B_TICK_M1:
                state_next = B_TICK_M2;
            B_TICK_M2:
                state_next = B_TICK_M3;
            B_TICK_M3:
                state_next = B_TICK_M4;
            B_TICK_M4:
                state_next = B_TICK_OUT;
            B_TICK_OUT:
                if (out_free)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == B_IDLE) && q_valid;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            cur_reg          <= '0;
            imu_arrival_reg  <= '0;
            pose_arrival_reg <= '0;
            prev_stamp_reg   <= '0;
            imu_vx_reg       <= '0;
            imu_vy_reg       <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            body_x_reg       <= '0;
            body_y_reg       <= '0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            filt_x_reg       <= '0;
            filt_y_reg       <= '0;
            imu_seen_reg     <= 1'b0;
            pose_seen_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_reg          <= '0;
            dt_reg           <= '0;
            numx_reg         <= '0;
            numy_reg         <= '0;
            quox_reg         <= '0;
            quoy_reg         <= '0;
            remx_reg         <= '0;
            remy_reg         <= '0;
            negx_reg         <= 1'b0;
            negy_reg         <= 1'b0;
            cnt_reg          <= '0;
            dq_reg           <= '0;
            pq_reg           <= '0;
            yz_reg           <= '0;
            sq_reg           <= '0;
            gx_reg           <= '0;
            gy_reg           <= '0;
            c_reg            <= '0;
            s_reg            <= '0;
            vx_reg           <= '0;
            vy_reg           <= '0;
            neg_reg          <= 1'b0;
            step_reg         <= '0;
            tx_reg           <= '0;
            ty_reg           <= '0;
            src_reg          <= SRC_NONE;
            healthy_reg      <= 1'b0;
            acc_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_TICK_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                    if (q_valid)
                    begin
                        cur_reg <= q_item.req;
                        case (q_item.op)
                            OP_IMU:
                            begin
                                imu_arrival_reg <= q_item.req.now_time;
                                imu_vx_reg      <= q_item.req.value_x;
                                imu_vy_reg      <= q_item.req.value_y;
                                imu_seen_reg    <= 1'b1;
                            end
                            OP_POSE:
                            begin
                                pose_arrival_reg <= q_item.req.now_time;
                                last_x_reg       <= q_item.req.value_x;
                                last_y_reg       <= q_item.req.value_y;
                                if (!pose_seen_reg || pose_go)
                                begin
                                    prev_stamp_reg <= q_item.req.sample_stamp;
                                    prev_x_reg     <= q_item.req.value_x;
                                    prev_y_reg     <= q_item.req.value_y;
                                end
                                if (!pose_seen_reg)
                                    pose_seen_reg <= 1'b1;
                                if (pose_go)
                                begin
                                    dt_reg   <= dt_new;
                                    numx_reg <= DIV_BITS'(ax) * DIV_BITS'(USEC_PER_SEC);
                                    numy_reg <= DIV_BITS'(ay) * DIV_BITS'(USEC_PER_SEC);
                                    negx_reg <= dx[32];
                                    negy_reg <= dy[32];
                                    remx_reg <= '0;
                                    remy_reg <= '0;
                                    quox_reg <= '0;
                                    quoy_reg <= '0;
                                    cnt_reg  <= '0;
                                    dq_reg   <= '0;
                                    pq_reg   <= '0;
                                    yz_reg   <= '0;
                                    sq_reg   <= '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                B_POSE_DIV:
                begin
                    remx_reg <= bx ? 32'(rsx - {1'b0, dt_reg}) : rsx[31:0];
                    remy_reg <= by ? 32'(rsy - {1'b0, dt_reg}) : rsy[31:0];
                    numx_reg <= numx_reg << 1;
                    numy_reg <= numy_reg << 1;
                    quox_reg <= qx_fin;
                    quoy_reg <= qy_fin;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg < DCW'(QUAT_PRODUCTS))
                    begin
                        case (cnt_reg[2:0])
                            3'd0, 3'd3: dq_reg <= dq_reg + qp;
                            3'd1, 3'd2:
                            begin
                                dq_reg <= dq_reg + qp;
                                yz_reg <= yz_reg + qp;
                            end
                            3'd4:       pq_reg <= pq_reg + qp;
                            3'd5:       pq_reg <= pq_reg - qp;
                            default:    sq_reg <= sq_reg + qp;
                        endcase
                    end
                    if (cnt_reg == DCW'(DIV_BITS-1))
                    begin
                        gx_reg <= sat_mag(qx_fin, negx_reg);
                        gy_reg <= sat_mag(qy_fin, negy_reg);
                    end
                end
                B_POSE_CHECK:
                begin
                    if (p2_abs >= 36'(dq_reg))
                    begin
                        body_x_reg <= gx_reg;
                        body_y_reg <= gy_reg;
                    end
                    neg_reg <= c_seed[35];
                    c_reg   <= c_seed[35] ? -c_seed : c_seed;
                    s_reg   <= c_seed[35] ? -s_seed : s_seed;
                end
                B_POSE_SCALE_X:
                    vx_reg <= sc_val;
                B_POSE_SCALE_Y:
                begin
                    vy_reg   <= sc_val;
                    step_reg <= '0;
                end
                B_POSE_CORDIC:
                begin
                    if (!s_reg[35])
                    begin
                        c_reg  <= c_reg + s_sh;
                        s_reg  <= s_reg - c_sh;
                        vx_reg <= vx_reg + vy_sh;
                        vy_reg <= vy_reg - vx_sh;
                    end
                    else
                    begin
                        c_reg  <= c_reg - s_sh;
                        s_reg  <= s_reg + c_sh;
                        vx_reg <= vx_reg - vy_sh;
                        vy_reg <= vy_reg + vx_sh;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                B_POSE_ROUND:
                begin
                    body_x_reg <= sat32(rx);
                    body_y_reg <= sat32(ry);
                end
                B_TICK_SEL:
                begin
                    healthy_reg <= imu_live || pose_live;
                    if (imu_live)
                    begin
                        tx_reg  <= imu_vx_reg;
                        ty_reg  <= imu_vy_reg;
                        src_reg <= SRC_IMU;
                    end
                    else if (pose_live)
                    begin
                        tx_reg  <= clx;
                        ty_reg  <= cly;
                        src_reg <= SRC_POSE;
                    end
                    else
                    begin
                        tx_reg  <= '0;
                        ty_reg  <= '0;
                        src_reg <= SRC_NONE;
                    end
                end
                B_TICK_M0:
                    acc_reg <= 52'(mprod);
                B_TICK_M1:
                    acc_reg <= acc_reg + 52'(mprod);
                B_TICK_M2:
                begin
                    filt_x_reg <= sat32(ema_val);
                    acc_reg    <= 52'(mprod);
                end
                B_TICK_M3:
                    acc_reg <= acc_reg + 52'(mprod);
                B_TICK_M4:
                    filt_y_reg <= sat32(ema_val);
                B_TICK_OUT:
                    if (out_free)
                    begin
                        out_reg.est_vel_x       <= filt_x_reg;
                        out_reg.est_vel_y       <= filt_y_reg;
                        out_reg.source_used     <= src_reg;
                        out_reg.sensors_healthy <= healthy_reg;
                        out_reg.pose_out_x      <= last_x_reg;
                        out_reg.pose_out_y      <= last_y_reg;
                    end
                default:
                begin
                end
            endcase
        end
    end

endmodule
